[rtl/color_palette_table_top_assert.svh]
// ----------------------------------------------------------------------------
// color_palette_table_top_assert.svh
// Assertion macros shared by the colour palette table modules.
// ----------------------------------------------------------------------------
`ifndef COLOR_PALETTE_TABLE_TOP_ASSERT_SVH
`define COLOR_PALETTE_TABLE_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its trigger
`define CPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger
`define CPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cpt_pkg.sv]
// ----------------------------------------------------------------------------
// cpt_pkg
// Operation codes, controller commands and the default xterm palette table.
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int unsigned EntryCount = 256;
    localparam int unsigned IndexWidth = 8;
    localparam int unsigned ColorWidth = 24;
    localparam int unsigned CountWidth = 9;

    // Operation codes carried by the func field
    typedef enum logic [1:0] {
        FUNC_SET       = 2'd0,
        FUNC_GET       = 2'd1,
        FUNC_RESET_ONE = 2'd2,
        FUNC_RESET_ALL = 2'd3
    } func_t;

    // Controller state, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_READ = 3'b100
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;  // latch the incoming word
        logic exec;     // update store, marks and count; launch the read
        logic finish;   // form the result word
    } cpt_cmd_t;

    typedef logic [ColorWidth-1:0] palette_t [EntryCount];

    localparam logic [ColorWidth-1:0] BasicColors [16] = '{
        24'h000000, 24'h800000, 24'h008000, 24'h808000,
        24'h000080, 24'h800080, 24'h008080, 24'hc0c0c0,
        24'h808080, 24'hff0000, 24'h00ff00, 24'hffff00,
        24'h0000ff, 24'hff00ff, 24'h00ffff, 24'hffffff
    };

    localparam int unsigned CubeFirst = 16;
    localparam int unsigned CubeSide  = 6;
    localparam int unsigned CubeBase  = 55;
    localparam int unsigned CubeStep  = 40;
    localparam int unsigned GrayFirst = 232;
    localparam int unsigned GraySteps = 24;
    localparam int unsigned GrayBase  = 8;
    localparam int unsigned GrayStep  = 10;

    // Component level of the colour cube
    function automatic logic [7:0] cube_level(input int unsigned k);
        logic [7:0] lvl;
        lvl = (k == 0) ? 8'd0 : 8'(k * CubeStep + CubeBase);
        return lvl;
    endfunction

    // Build the default palette at elaboration
    function automatic palette_t build_palette();
        palette_t    p;
        int unsigned slot;
        logic [7:0]  gv;
        for (int i = 0; i < 16; i++)
        begin
            p[i] = BasicColors[i];
        end
        slot = CubeFirst;
        for (int r = 0; r < CubeSide; r++)
        begin
            for (int g = 0; g < CubeSide; g++)
            begin
                for (int b = 0; b < CubeSide; b++)
                begin
                    p[slot] = {cube_level(r), cube_level(g), cube_level(b)};
                    slot++;
                end
            end
        end
        for (int k = 0; k < GraySteps; k++)
        begin
            gv = 8'(k * GrayStep + GrayBase);
            p[GrayFirst + k] = {gv, gv, gv};
        end
        return p;
    endfunction

    localparam palette_t DefaultPalette = build_palette();

endpackage

[rtl/cpt_ctrl.sv]
// ----------------------------------------------------------------------------
// cpt_ctrl
// Sequencer: accept a word, run the store update, then form the result.
// ----------------------------------------------------------------------------
module cpt_ctrl
    import cpt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output cpt_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // Advance through update and read
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_READ;
            ST_READ: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode commands
    assign busy        = (state_reg != ST_IDLE);
    assign cmd.capture = (state_reg == ST_IDLE) && start;
    assign cmd.exec    = (state_reg == ST_EXEC);
    assign cmd.finish  = (state_reg == ST_READ);

endmodule

[rtl/cpt_datapath.sv]
// ----------------------------------------------------------------------------
// cpt_datapath
// Colour memory, modified marks, running count and result register.
// ----------------------------------------------------------------------------
`include "color_palette_table_top_assert.svh"

module cpt_datapath
    import cpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cpt_cmd_t              cmd,
    input  logic [1:0]            func,
    input  logic [IndexWidth-1:0] index,
    input  logic [ColorWidth-1:0] new_color,
    output logic                  valid,
    output logic [ColorWidth-1:0] color_out,
    output logic                  entry_modified,
    output logic [CountWidth-1:0] modified_count
);

    // Latched word
    func_t                 func_reg;
    logic [IndexWidth-1:0] index_reg;
    logic [ColorWidth-1:0] color_reg;

    // Colour memory; only entries with their mark set are meaningful
    logic [ColorWidth-1:0] color_mem [EntryCount];
    logic [ColorWidth-1:0] rd_data_reg;

    logic [EntryCount-1:0] mark_reg;
    logic [EntryCount-1:0] mark_next;
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;

    logic                  valid_reg;
    logic [ColorWidth-1:0] out_color_reg;
    logic [ColorWidth-1:0] out_color_next;
    logic                  out_mark_reg;
    logic [CountWidth-1:0] out_count_reg;

    logic                  cur_mark;

    assign cur_mark = mark_reg[index_reg];

    // Hold the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func_t'(func);
            index_reg <= index;
            color_reg <= new_color;
        end
    end

    // Write on set, read the addressed entry every update cycle
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (func_reg == FUNC_SET)
            begin
                color_mem[index_reg] <= color_reg;
            end
            rd_data_reg <= color_mem[index_reg];
        end
    end

    // Update marks and count
    always_comb
    begin
        mark_next  = mark_reg;
        count_next = count_reg;
        if (cmd.exec)
        begin
            case (func_reg)
                FUNC_SET:
                begin
                    mark_next[index_reg] = 1'b1;
                    if (!cur_mark)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                FUNC_RESET_ONE:
                begin
                    mark_next[index_reg] = 1'b0;
                    if (cur_mark)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                FUNC_RESET_ALL:
                begin
                    mark_next  = '0;
                    count_next = '0;
                end
                default:
                begin
                    mark_next  = mark_reg;
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            mark_reg  <= mark_next;
            count_reg <= count_next;
        end
    end

    // Pick the result colour: zero on reset all, the new colour on set, else unmarked entries show their default
    always_comb
    begin
        if (func_reg == FUNC_RESET_ALL)
        begin
            out_color_next = '0;
        end
        else if (func_reg == FUNC_SET)
        begin
            out_color_next = color_reg;
        end
        else if (cur_mark)
        begin
            out_color_next = rd_data_reg;
        end
        else
        begin
            out_color_next = DefaultPalette[index_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_color_reg <= out_color_next;
            out_mark_reg  <= cur_mark;
            out_count_reg <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.finish;
        end
    end

    assign valid          = valid_reg;
    assign color_out      = out_color_reg;
    assign entry_modified = out_mark_reg;
    assign modified_count = out_count_reg;

    `CPT_ASSERT_NOW(a_count_matches_marks, clk, rst_n, 1'b1,
        count_reg == CountWidth'($countones(mark_reg)), "count differs from marks")
    `CPT_ASSERT_NEXT(a_set_marks_entry, clk, rst_n, cmd.exec && func_reg == FUNC_SET,
        mark_reg[index_reg], "set left entry unmarked")
    `CPT_ASSERT_NEXT(a_reset_one_clears, clk, rst_n,
        cmd.exec && func_reg == FUNC_RESET_ONE,
        !mark_reg[index_reg], "reset one left entry marked")
    `CPT_ASSERT_NEXT(a_reset_all_zero, clk, rst_n,
        cmd.finish && func_reg == FUNC_RESET_ALL,
        color_out == '0 && !entry_modified && modified_count == '0,
        "reset all result not zero")

endmodule

[rtl/color_palette_table_top.sv]
// ----------------------------------------------------------------------------
// color_palette_table_top
// 256-entry 24-bit colour lookup table with xterm default contents.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Its result appears on
// color_out, entry_modified and modified_count, marked by valid for exactly
// one cycle; the receiver cannot stall it. Every operation, reset all
// included, passes through three steps: one to latch the word, one to update
// the marks and access the colour memory, and one behind the memory's
// registered read port to form the result, which is then registered with
// valid. The next word may be started in the cycle the result is shown, so
// the block takes no new word while one is still in progress. Reset all
// clears every modified mark in its update step; an unmarked entry always
// reads its default colour, so no clearing pass over the colour memory is
// needed after reset.
// ----------------------------------------------------------------------------
`include "color_palette_table_top_assert.svh"

module color_palette_table_top
    import cpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            func,
    input  logic [IndexWidth-1:0] index,
    input  logic [ColorWidth-1:0] new_color,
    output logic                  valid,
    output logic [ColorWidth-1:0] color_out,
    output logic                  entry_modified,
    output logic [CountWidth-1:0] modified_count
);

    cpt_cmd_t cmd;

    cpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    cpt_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .func           (func),
        .index          (index),
        .new_color      (new_color),
        .valid          (valid),
        .color_out      (color_out),
        .entry_modified (entry_modified),
        .modified_count (modified_count)
    );

    `CPT_ASSERT_NOW(a_result_follows_busy, clk, rst_n, valid,
        $past(busy) && !busy, "result word without a finished operation")

endmodule

[tb/sv/color_palette_table_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_palette_table_top_tb
// Self-checking bench for the 256-entry colour palette table. A short table of
// directed words (defaults, extremes, marks and the running count) is followed
// by random words and full sweeps of sets, checked against the expected words
// typed into the table or against a shadow copy of the palette kept in the bench.
// ----------------------------------------------------------------------------
module color_palette_table_top_tb;

    import cpt_pkg::*;

    localparam int unsigned CUBE_START = 16;
    localparam int unsigned GREY_START = 232;
    localparam int unsigned CUBE_SIDE  = 6;
    localparam int unsigned LEVEL_BASE = 55;
    localparam int unsigned LEVEL_STEP = 40;
    localparam int unsigned GREY_BASE  = 8;
    localparam int unsigned GREY_STEP  = 10;
    localparam int unsigned PHASE_WORDS = 500;

    // One result word as seen on the output ports
    typedef struct packed {
        logic [ColorWidth-1:0] color;
        logic                  modified;
        logic [CountWidth-1:0] count;
    } palette_word_t;

    // One row of the directed table
    typedef struct {
        func_t                 op;
        logic [IndexWidth-1:0] slot;
        logic [ColorWidth-1:0] rgb;
        bit                    typed_in;
        palette_word_t         want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            func = FUNC_GET;
    logic [IndexWidth-1:0] index = '0;
    logic [ColorWidth-1:0] new_color = '0;
    logic                  valid;
    logic [ColorWidth-1:0] color_out;
    logic                  entry_modified;
    logic [CountWidth-1:0] modified_count;

    // Shadow palette state
    logic [ColorWidth-1:0] shadow_colors [EntryCount];
    bit                    shadow_marks [EntryCount];
    logic [CountWidth-1:0] shadow_count;

    palette_word_t pending_results [$];
    stim_row_t     directed_rows [$];
    int            mismatch_count = 0;
    int            sender_gap_pct = 0;

    color_palette_table_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .index          (index),
        .new_color      (new_color),
        .valid          (valid),
        .color_out      (color_out),
        .entry_modified (entry_modified),
        .modified_count (modified_count)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Default xterm colour of one entry
    function automatic logic [ColorWidth-1:0] xterm_default(input logic [IndexWidth-1:0] slot);
        logic [7:0]  comp [3];
        logic [7:0]  grey;
        int unsigned cube_pos;
        int unsigned digit;
        if (slot < CUBE_START)
        begin
            case (slot[3:0])
                4'd0:    return 24'h000000;
                4'd1:    return 24'h800000;
                4'd2:    return 24'h008000;
                4'd3:    return 24'h808000;
                4'd4:    return 24'h000080;
                4'd5:    return 24'h800080;
                4'd6:    return 24'h008080;
                4'd7:    return 24'hc0c0c0;
                4'd8:    return 24'h808080;
                4'd9:    return 24'hff0000;
                4'd10:   return 24'h00ff00;
                4'd11:   return 24'hffff00;
                4'd12:   return 24'h0000ff;
                4'd13:   return 24'hff00ff;
                4'd14:   return 24'h00ffff;
                default: return 24'hffffff;
            endcase
        end
        if (slot < GREY_START)
        begin
            cube_pos = slot - CUBE_START;
            for (int i = 0; i < 3; i++)
            begin
                digit = (i == 0) ? cube_pos / (CUBE_SIDE * CUBE_SIDE) :
                        (i == 1) ? (cube_pos / CUBE_SIDE) % CUBE_SIDE :
                                   cube_pos % CUBE_SIDE;
                comp[i] = (digit == 0) ? 8'd0 : 8'(digit * LEVEL_STEP + LEVEL_BASE);
            end
            return {comp[0], comp[1], comp[2]};
        end
        grey = 8'((slot - GREY_START) * GREY_STEP + GREY_BASE);
        return {grey, grey, grey};
    endfunction

    // Restore every default colour and clear every mark
    function automatic void restore_palette();
        for (int s = 0; s < EntryCount; s++)
        begin
            shadow_colors[s] = xterm_default(s[IndexWidth-1:0]);
            shadow_marks[s]  = 1'b0;
        end
        shadow_count = '0;
    endfunction

    // Apply one word to the shadow palette and return the word it yields
    function automatic palette_word_t apply_palette_op(input func_t op,
                                                       input logic [IndexWidth-1:0] slot,
                                                       input logic [ColorWidth-1:0] rgb);
        palette_word_t res;
        case (op)
            FUNC_RESET_ALL:
            begin
                restore_palette();
                res = '0;
                return res;
            end
            FUNC_SET:
            begin
                shadow_colors[slot] = rgb;
                if (!shadow_marks[slot])
                begin
                    shadow_marks[slot] = 1'b1;
                    shadow_count       = shadow_count + 1'b1;
                end
            end
            FUNC_RESET_ONE:
            begin
                shadow_colors[slot] = xterm_default(slot);
                if (shadow_marks[slot])
                begin
                    shadow_marks[slot] = 1'b0;
                    shadow_count       = shadow_count - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.color    = shadow_colors[slot];
        res.modified = shadow_marks[slot];
        res.count    = shadow_count;
        return res;
    endfunction

    // Print one mismatch and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Offer one word, idle at random first, and record its expected result
    task automatic send_word(input func_t op, input logic [IndexWidth-1:0] slot,
                             input logic [ColorWidth-1:0] rgb, input bit typed_in,
                             input palette_word_t want);
        palette_word_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start     <= 1'b1;
        func      <= op;
        index     <= slot;
        new_color <= rgb;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_palette_op(op, slot, rgb);
        pending_results.push_back(typed_in ? want : predicted);
    endtask

    // Random word: mostly sets and gets, reset all kept rare
    task automatic send_random_word();
        int    pick;
        func_t op;
        pick = $urandom_range(99);
        op   = (pick < 40) ? FUNC_SET :
               (pick < 75) ? FUNC_GET :
               (pick < 97) ? FUNC_RESET_ONE : FUNC_RESET_ALL;
        send_word(op, IndexWidth'($urandom_range(255)), ColorWidth'($urandom()), 1'b0, '0);
    endtask

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        palette_word_t want;
        if (rst_n && valid)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected word", {8'd0, color_out}, 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (color_out !== want.color)
                    report_mismatch("color_out", 32'(color_out), 32'(want.color));
                if (entry_modified !== want.modified)
                    report_mismatch("entry_modified", 32'(entry_modified),
                                    32'(want.modified));
                if (modified_count !== want.count)
                    report_mismatch("modified_count", 32'(modified_count),
                                    32'(want.count));
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        restore_palette();

        // Defaults after reset, then marks, the count and reset all
        directed_rows.push_back('{FUNC_GET, 8'd0, 24'h000000, 1'b1, '{24'h000000, 1'b0, 9'd0}});
        directed_rows.push_back('{FUNC_GET, 8'd1, 24'hffffff, 1'b1, '{24'h800000, 1'b0, 9'd0}});
        directed_rows.push_back('{FUNC_GET, 8'd7, 24'h000000, 1'b1, '{24'hc0c0c0, 1'b0, 9'd0}});
        directed_rows.push_back('{FUNC_GET, 8'd8, 24'h000000, 1'b1, '{24'h808080, 1'b0, 9'd0}});
        directed_rows.push_back('{FUNC_GET, 8'd15, 24'h000000, 1'b1, '{24'hffffff, 1'b0, 9'd0}});
        directed_rows.push_back('{FUNC_GET, 8'd16, 24'h000000, 1'b1, '{24'h000000, 1'b0, 9'd0}});
        directed_rows.push_back('{FUNC_GET, 8'd17, 24'h000000, 1'b1, '{24'h00005f, 1'b0, 9'd0}});
        directed_rows.push_back('{FUNC_GET, 8'd100, 24'h000000, 1'b0, '0});
        directed_rows.push_back('{FUNC_GET, 8'd231, 24'h000000, 1'b1, '{24'hffffff, 1'b0, 9'd0}});
        directed_rows.push_back('{FUNC_GET, 8'd232, 24'h000000, 1'b1, '{24'h080808, 1'b0, 9'd0}});
        directed_rows.push_back('{FUNC_GET, 8'd255, 24'h000000, 1'b1, '{24'heeeeee, 1'b0, 9'd0}});
        directed_rows.push_back('{FUNC_SET, 8'd0, 24'hffffff, 1'b1, '{24'hffffff, 1'b1, 9'd1}});
        directed_rows.push_back('{FUNC_SET, 8'd255, 24'h000000, 1'b1, '{24'h000000, 1'b1, 9'd2}});
        directed_rows.push_back('{FUNC_SET, 8'd255, 24'h123456, 1'b1, '{24'h123456, 1'b1, 9'd2}});
        directed_rows.push_back('{FUNC_GET, 8'd255, 24'h000000, 1'b1, '{24'h123456, 1'b1, 9'd2}});
        directed_rows.push_back('{FUNC_RESET_ONE, 8'd255, 24'h0, 1'b1, '{24'heeeeee, 1'b0, 9'd1}});
        directed_rows.push_back('{FUNC_RESET_ONE, 8'd255, 24'h0, 1'b1, '{24'heeeeee, 1'b0, 9'd1}});
        directed_rows.push_back('{FUNC_RESET_ONE, 8'd100, 24'h0, 1'b0, '0});
        directed_rows.push_back('{FUNC_SET, 8'd128, 24'haaaaaa, 1'b0, '0});
        directed_rows.push_back('{FUNC_SET, 8'd127, 24'h555555, 1'b0, '0});
        directed_rows.push_back('{FUNC_RESET_ALL, 8'd77, 24'hffffff, 1'b1, '{24'h0, 1'b0, 9'd0}});
        directed_rows.push_back('{FUNC_GET, 8'd0, 24'h000000, 1'b1, '{24'h000000, 1'b0, 9'd0}});
        directed_rows.push_back('{FUNC_GET, 8'd128, 24'h000000, 1'b0, '0});
        directed_rows.push_back('{FUNC_RESET_ALL, 8'd0, 24'h000000, 1'b1, '{24'h0, 1'b0, 9'd0}});

        // Hold reset, then release it once
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sender_gap_pct = 37;
        foreach (directed_rows[i])
        begin
            send_word(directed_rows[i].op, directed_rows[i].slot, directed_rows[i].rgb,
                      directed_rows[i].typed_in, directed_rows[i].want);
        end

        // Three idling phases; each opens with a sweep of sets to fill every mark
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_gap_pct = (phase == 0) ? 37 : (phase == 1) ? 82 : 0;
            for (int s = 0; s < EntryCount; s++)
            begin
                send_word(FUNC_SET, s[IndexWidth-1:0], ColorWidth'($urandom()), 1'b0, '0);
            end
            for (int n = EntryCount; n < PHASE_WORDS; n++)
            begin
                send_random_word();
            end
        end

        @(negedge clk);
        start <= 1'b0;

        // Drain outstanding words, then allow for the pipeline
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #3ms;
        $display("FAIL");
        $finish;
    end

endmodule

[color_palette_table_top.f]
+incdir+rtl
rtl/cpt_pkg.sv
rtl/cpt_ctrl.sv
rtl/cpt_datapath.sv
rtl/color_palette_table_top.sv
tb/sv/color_palette_table_top_tb.sv
